// File: src/edf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types and constants for the streaming 3x3 edge filter.
// ----------------------------------------------------------------------------
package edf_pkg;

    localparam int PIX_W       = 8;
    localparam int RESP_W      = 11;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = CFG_INDEX_W'(1);

    // one window column, top row first
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } col_t;

endpackage

// File: src/edf_col_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_col_cell
// One 3x3 window column; on shift loads its neighbor's column or the new one.
// ----------------------------------------------------------------------------
module edf_col_cell
    import edf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic shift,
    input  col_t col_in,
    output col_t col_out
);

    col_t col_reg;
    col_t col_next;

    always_comb
    begin
        col_next = col_reg;
        if (shift)
        begin
            col_next = col_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    assign col_out = col_reg;

endmodule

// File: src/edf_line_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_line_buf
// Two line stores holding the previous two rows, registered read with
// write-to-read forwarding on a same-address collision.
// ----------------------------------------------------------------------------
module edf_line_buf
    import edf_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [PIX_W-1:0]         wr_pixel,
    output logic [PIX_W-1:0]         top_q,
    output logic [PIX_W-1:0]         mid_q
);

    logic [PIX_W-1:0] older_mem [DEPTH];
    logic [PIX_W-1:0] newer_mem [DEPTH];
    logic [PIX_W-1:0] top_reg;
    logic [PIX_W-1:0] mid_reg;
    logic             collide;

    assign collide = wr_en && (wr_addr == rd_addr);

    // older row takes what was the newer row at this column
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            older_mem[wr_addr] <= mid_reg;
            newer_mem[wr_addr] <= wr_pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (collide)
            begin
                top_reg <= mid_reg;
                mid_reg <= wr_pixel;
            end
            else
            begin
                top_reg <= older_mem[rd_addr];
                mid_reg <= newer_mem[rd_addr];
            end
        end
    end

    assign top_q = top_reg;
    assign mid_q = mid_reg;

endmodule

// File: src/edf_kernel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_kernel
// Laplacian and horizontal Sobel sums over the window, into the output
// register.
// ----------------------------------------------------------------------------
module edf_kernel
    import edf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  col_t                     c0,
    input  col_t                     c1,
    input  col_t                     c2,
    input  logic                     win_valid,
    input  logic                     win_last,
    output logic                     win_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [RESP_W-1:0] laplace_raw,
    output logic [PIX_W-1:0]         laplace_byte,
    output logic signed [RESP_W-1:0] sobel_raw,
    output logic                     edge_mask,
    output logic                     frame_last
);

    localparam int SUM_W = RESP_W + 1;

    logic signed [SUM_W-1:0]  lap_sum;
    logic signed [SUM_W-1:0]  sob_sum;
    logic                     valid_reg;
    logic                     valid_next;
    logic signed [RESP_W-1:0] lap_reg;
    logic signed [RESP_W-1:0] sob_reg;
    logic                     last_reg;
    logic                     load;

    always_comb
    begin
        lap_sum = signed'(SUM_W'(c1.top)) + signed'(SUM_W'(c0.mid))
                + signed'(SUM_W'(c2.mid)) + signed'(SUM_W'(c1.bot))
                - signed'(SUM_W'({c1.mid, 2'b00}));
        sob_sum = (signed'(SUM_W'(c2.top)) - signed'(SUM_W'(c0.top)))
                + (signed'(SUM_W'({c2.mid, 1'b0})) - signed'(SUM_W'({c0.mid, 1'b0})))
                + (signed'(SUM_W'(c2.bot)) - signed'(SUM_W'(c0.bot)));
    end

    assign win_ready = !valid_reg || out_ready;
    assign load      = win_valid && win_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lap_reg  <= lap_sum[RESP_W-1:0];
            sob_reg  <= sob_sum[RESP_W-1:0];
            last_reg <= win_last;
        end
    end

    assign out_valid    = valid_reg;
    assign laplace_raw  = lap_reg;
    assign laplace_byte = lap_reg[PIX_W-1:0];
    assign sobel_raw    = sob_reg;
    assign edge_mask    = |sob_reg[PIX_W-1:0];
    assign frame_last   = last_reg;

endmodule

// File: src/edge_filter_3x3_stream_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_filter_3x3_stream_top
// Streaming 3x3 Laplacian and horizontal Sobel edge filter on raster pixels.
// ----------------------------------------------------------------------------
// Accepts one pixel beat per clock unless the output stalls, and returns one
// result beat per interior pixel; the beat completing its window goes through
// the window shift, then the output register. Pixels of the first two rows
// and of the first two columns of each row give no result. A configuration
// write clamps the value to 3..MAX and restarts the frame at row 0, column 0;
// write it only with no beat in flight. Line stores need no clearing pass.
module edge_filter_3x3_stream_top
    import edf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [PIX_W-1:0]         pixel,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [RESP_W-1:0] laplace_raw,
    output logic [PIX_W-1:0]         laplace_byte,
    output logic signed [RESP_W-1:0] sobel_raw,
    output logic                     edge_mask,
    output logic                     frame_last
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WD_W  = $clog2(MAX_WIDTH + 1);
    localparam int HT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int M1    = (CW + 1 > RW + 1) ? CW + 1 : RW + 1;
    localparam int M2    = (WD_W > HT_W) ? WD_W : HT_W;
    localparam int M3    = (M1 > M2) ? M1 : M2;
    localparam int CMP_W = (M3 > CFG_DATA_W) ? M3 : CFG_DATA_W;
    localparam int RST_WIDTH  = (MAX_WIDTH < 512) ? MAX_WIDTH : 512;
    localparam int RST_HEIGHT = (MAX_HEIGHT < 512) ? MAX_HEIGHT : 512;

    function automatic logic [CMP_W-1:0] clamp_dim(
        input logic [CFG_DATA_W-1:0] v,
        input logic [CMP_W-1:0]      hi
    );
        logic [CMP_W-1:0] ve;
        ve = CMP_W'(v);
        if (ve < CMP_W'(3))
        begin
            return CMP_W'(3);
        end
        else if (ve > hi)
        begin
            return hi;
        end
        return ve;
    endfunction

    logic [WD_W-1:0]  frame_width_reg;
    logic [WD_W-1:0]  frame_width_next;
    logic [HT_W-1:0]  frame_height_reg;
    logic [HT_W-1:0]  frame_height_next;
    logic [CW-1:0]    col_cnt_reg;
    logic [CW-1:0]    col_cnt_next;
    logic [RW-1:0]    row_cnt_reg;
    logic [RW-1:0]    row_cnt_next;
    logic [CMP_W-1:0] col_inc;
    logic [CMP_W-1:0] row_inc;
    logic             col_wrap;
    logic             row_wrap;
    logic             cfg_write;
    logic             cfg_hit;
    logic             in_accept;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [CW-1:0]    s1_col_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    logic             s1_adv;

    logic             s2_valid_reg;
    logic             s2_valid_next;
    logic             s2_last_reg;
    logic             s2_ready;

    logic [PIX_W-1:0] top_q;
    logic [PIX_W-1:0] mid_q;
    col_t             new_col;
    col_t             c0;
    col_t             c1;
    col_t             c2;

    // configuration
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_write
                    && ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    frame_width_next = WD_W'(clamp_dim(cfg_data, CMP_W'(MAX_WIDTH)));
                end
                REG_FRAME_HEIGHT:
                begin
                    frame_height_next = HT_W'(clamp_dim(cfg_data, CMP_W'(MAX_HEIGHT)));
                end
                default:
                begin
                end
            endcase
        end
    end

    // position counters
    assign in_accept = in_valid && in_ready;
    assign col_inc   = CMP_W'(col_cnt_reg) + CMP_W'(1);
    assign row_inc   = CMP_W'(row_cnt_reg) + CMP_W'(1);
    assign col_wrap  = col_inc >= CMP_W'(frame_width_reg);
    assign row_wrap  = row_inc >= CMP_W'(frame_height_reg);

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (cfg_hit)
        begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
        else if (in_accept)
        begin
            if (col_wrap)
            begin
                col_cnt_next = '0;
                row_cnt_next = row_wrap ? '0 : RW'(row_inc);
            end
            else
            begin
                col_cnt_next = CW'(col_inc);
            end
        end
    end

    // stage one: pixel waits for its line store read
    assign s1_adv   = s1_valid_reg && (!s2_valid_reg || s2_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // stage two: window holds an interior centre
    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (s1_adv)
        begin
            s2_valid_next = s1_emit_reg;
        end
        else if (s2_ready)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WD_W'(RST_WIDTH);
            frame_height_reg <= HT_W'(RST_HEIGHT);
            col_cnt_reg      <= '0;
            row_cnt_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            col_cnt_reg      <= col_cnt_next;
            row_cnt_reg      <= row_cnt_next;
            s1_valid_reg     <= s1_valid_next;
            s2_valid_reg     <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pix_reg  <= pixel;
            s1_col_reg  <= col_cnt_reg;
            s1_emit_reg <= (row_cnt_reg >= RW'(2)) && (col_cnt_reg >= CW'(2));
            s1_last_reg <= row_wrap && col_wrap;
        end
        if (s1_adv)
        begin
            s2_last_reg <= s1_last_reg;
        end
    end

    edf_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk      (clk),
        .rd_en    (in_accept),
        .rd_addr  (col_cnt_reg),
        .wr_en    (s1_adv),
        .wr_addr  (s1_col_reg),
        .wr_pixel (s1_pix_reg),
        .top_q    (top_q),
        .mid_q    (mid_q)
    );

    assign new_col.top = top_q;
    assign new_col.mid = mid_q;
    assign new_col.bot = s1_pix_reg;

    // window cells, newest column first
    edf_col_cell u_cell2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (s1_adv),
        .col_in  (new_col),
        .col_out (c2)
    );

    edf_col_cell u_cell1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (s1_adv),
        .col_in  (c2),
        .col_out (c1)
    );

    edf_col_cell u_cell0 (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (s1_adv),
        .col_in  (c1),
        .col_out (c0)
    );

    edf_kernel u_kernel (
        .clk          (clk),
        .rst_n        (rst_n),
        .c0           (c0),
        .c1           (c1),
        .c2           (c2),
        .win_valid    (s2_valid_reg),
        .win_last     (s2_last_reg),
        .win_ready    (s2_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .laplace_raw  (laplace_raw),
        .laplace_byte (laplace_byte),
        .sobel_raw    (sobel_raw),
        .edge_mask    (edge_mask),
        .frame_last   (frame_last)
    );

endmodule
